>>> rtl/core/bdlp_pkg.sv
package bdlp_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [1:0] REG_FEEDBACK   = 2'd2;

  // Reset values of the timing registers, in ms
  localparam logic [15:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [15:0] FEEDBACK_RST   = 16'd2000;

  // Field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned InTdW  = 40;
  localparam int unsigned OutTdW = 8;

  // Reported button status
  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_PRESSED = 2'd1,
    ST_CLEAR   = 2'd2
  } status_e;

  // Timing configuration handed to the step logic
  typedef struct packed {
    logic [CfgW-1:0] debounce;
    logic [CfgW-1:0] long_press;
    logic [CfgW-1:0] feedback;
  } cfg_t;

  // One result item
  typedef struct packed {
    status_e status;
    logic    clear_request;
  } result_t;

endpackage

>>> rtl/core/bdlp_cfg.sv
module bdlp_cfg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [15:0]           cfg_wdata_i,
  output bdlp_pkg::cfg_t        cfg_o
);
  import bdlp_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Register write decode; an index beyond the list is dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEBOUNCE:   cfg_d.debounce   = cfg_wdata_i;
        REG_LONG_PRESS: cfg_d.long_press = cfg_wdata_i;
        REG_FEEDBACK:   cfg_d.feedback   = cfg_wdata_i;
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce   <= DEBOUNCE_RST;
      cfg_q.long_press <= LONG_PRESS_RST;
      cfg_q.feedback   <= FEEDBACK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/bdlp_core.sv
module bdlp_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bdlp_pkg::cfg_t                cfg_i,
  input  logic                          step_i,
  input  logic                          raw_i,
  input  logic [bdlp_pkg::TimeW-1:0]    now_i,
  output bdlp_pkg::result_t             res_o
);
  import bdlp_pkg::*;

  typedef struct packed {
    logic             pressed;
    logic             last_raw;
    logic [TimeW-1:0] stable_since;
    logic [TimeW-1:0] press_since;
    logic             long_done;
    status_e          status;
    logic [TimeW-1:0] status_since;
  } state_t;

  state_t st_q, st_d;

  logic [TimeW-1:0] stable_age, press_age, status_age;
  logic             accept, rise, pulse;

  // Elapsed times, modulo 2^32
  assign stable_age = now_i - st_q.stable_since;
  assign status_age = now_i - st_q.status_since;
  // A press accepted on this poll restarts the press timer at zero
  assign press_age  = rise ? '0 : (now_i - st_q.press_since);

  assign accept = (raw_i == st_q.last_raw) && (raw_i != st_q.pressed) &&
                  (stable_age >= {{(TimeW-CfgW){1'b0}}, cfg_i.debounce});
  assign rise   = accept && raw_i;
  assign pulse  = (raw_i == st_q.last_raw) && (accept ? raw_i : st_q.pressed) &&
                  !(rise ? 1'b0 : st_q.long_done) &&
                  (press_age >= {{(TimeW-CfgW){1'b0}}, cfg_i.long_press});

  // Next state and result for the poll
  always_comb begin
    st_d = st_q;
    if (raw_i != st_q.last_raw) begin
      st_d.last_raw     = raw_i;
      st_d.stable_since = now_i;
    end else begin
      if (accept) begin
        st_d.pressed = raw_i;
      end
      if (rise) begin
        st_d.press_since  = now_i;
        st_d.long_done    = 1'b0;
        st_d.status       = ST_PRESSED;
        st_d.status_since = now_i;
      end
      if (pulse) begin
        st_d.long_done    = 1'b1;
        st_d.status       = ST_CLEAR;
        st_d.status_since = now_i;
      end
    end

    // Status evaluation after the poll; the feedback timeout only applies while
    // the button is released and the status is not ST_CLEAR, so never on a poll with a press or a clear request
    res_o.clear_request = pulse;
    if (st_d.pressed) begin
      res_o.status = ST_PRESSED;
    end else if (st_d.status == ST_CLEAR) begin
      res_o.status = ST_CLEAR;
    end else begin
      if ((st_d.status != ST_IDLE) &&
          (status_age >= {{(TimeW-CfgW){1'b0}}, cfg_i.feedback})) begin
        st_d.status = ST_IDLE;
      end
      res_o.status = st_d.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{pressed: 1'b0, last_raw: 1'b0, stable_since: '0, press_since: '0,
                long_done: 1'b0, status: ST_IDLE, status_since: '0};
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

endmodule

>>> rtl/core/button_debounce_long_press.sv
// Button debounce with long-press detection. Each input item is one poll of
// the button (raw level and millisecond timestamp) and yields exactly one
// result item (clear-request pulse and status). Items pass through an input
// register and an output register, and the debounce and status state is
// updated as an item moves between them, so a poll can be accepted every
// clock while the output is not stalled. A result is offered from the output
// register. The user must write timing registers through the cfg port only
// while no poll is in flight; the block itself does not enforce this.
module button_debounce_long_press (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write port
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [15:0]                 cfg_wdata_i,
  // Poll input
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [bdlp_pkg::InTdW-1:0]  s_tdata,  // [0] raw_level, [32:1] time_now, zero pad
  // Result output
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [bdlp_pkg::OutTdW-1:0] m_tdata   // [0] clear_request, [2:1] button_status, pad
);
  import bdlp_pkg::*;

  cfg_t             cfg;
  result_t          res;
  logic             in_vld_q;
  logic             in_raw_q;
  logic [TimeW-1:0] in_now_q;
  logic             out_vld_q;
  result_t          out_res_q;
  logic             advance;

  // An item moves on when the output slot is free or being drained
  assign advance  = in_vld_q && (!out_vld_q || m_tready);
  assign s_tready = !in_vld_q || advance;

  bdlp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bdlp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (advance),
    .raw_i  (in_raw_q),
    .now_i  (in_now_q),
    .res_o  (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_tready) begin
      in_vld_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready && s_tvalid) begin
      in_raw_q <= s_tdata[0];
      in_now_q <= s_tdata[TimeW:1];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_tvalid = out_vld_q;
  assign m_tdata  = {5'b0, out_res_q.status, out_res_q.clear_request};

endmodule

>>> rtl/core/bdlp_checker.sv
module bdlp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);
  import bdlp_pkg::*;

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // The clear request only fires while the button is held
  a_pulse_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tdata[0] |-> m_tdata[2:1] == ST_PRESSED)
    else $error("clear request without pressed status");

  // Only the defined status codes are reported
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> (m_tdata[2:1] == ST_IDLE || m_tdata[2:1] == ST_PRESSED ||
                  m_tdata[2:1] == ST_CLEAR))
    else $error("invalid status code");

  // Padding bits stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> m_tdata[7:3] == 5'd0)
    else $error("nonzero padding in result");

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
